/* design/tlsu_pkg.sv */
// Shared codes, stage payload types and helpers for the Thumb logic/shift unit.
package tlsu_pkg;

  localparam logic [3:0] CMD_AND     = 4'd0;
  localparam logic [3:0] CMD_BIC     = 4'd1;
  localparam logic [3:0] CMD_EOR     = 4'd2;
  localparam logic [3:0] CMD_ORR     = 4'd3;
  localparam logic [3:0] CMD_MVN     = 4'd4;
  localparam logic [3:0] CMD_ASR_IMM = 4'd5;
  localparam logic [3:0] CMD_ASR_REG = 4'd6;
  localparam logic [3:0] CMD_LSL_IMM = 4'd7;
  localparam logic [3:0] CMD_LSR_IMM = 4'd8;
  localparam logic [3:0] CMD_LSL_REG = 4'd9;
  localparam logic [3:0] CMD_LSR_REG = 4'd10;
  localparam logic [3:0] CMD_ROR     = 4'd11;

  // Shift amounts: 32 shifts every data bit out, 33 clears the carry slot as well
  localparam logic [5:0] SHIFT_ALL = 6'd32;
  localparam logic [5:0] SHIFT_OUT = 6'd33;

  // Stage 1 -> 2: 65-bit window {fill, value, carry} shifted right by amt
  typedef struct packed {
    logic [31:0] fill;
    logic [31:0] value;
    logic        cin;
    logic [5:0]  amt;
    logic        rev;
    logic        rot_c;
  } dec_t;

  // Stage 2 -> 3: window after the coarse (multiple of eight) shift
  typedef struct packed {
    logic [39:0] win;
    logic [2:0]  fine;
    logic        rev;
    logic        rot_c;
  } crs_t;

  // Stage 3 -> 4
  typedef struct packed {
    logic [31:0] result;
    logic        carry;
  } shf_t;

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

endpackage

/* design/thumb_logic_shift_unit.sv */
// Thumb logical and shift ALU: decode, coarse shift, fine shift, flags.
// An accepted input beat passes through the dec, crs, shf and output registers to the result beat.
// Throughput: one beat per cycle; each of the four register stages holds its
// beat only while the stage after it is full and stalled.
// Reset (synchronous, rst high) empties every stage; payload is not cleared.
module thumb_logic_shift_unit import tlsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  cmd,
  input  logic [31:0] dest_value,
  input  logic [31:0] src_value,
  input  logic [4:0]  shift_imm,
  input  logic        carry_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result,
  output logic        negative,
  output logic        zero,
  output logic        carry_out
);

  logic in_ready;
  logic dec_valid;
  logic dec_ready;
  dec_t dec;
  logic shf_valid;
  logic shf_ready;
  shf_t shf;

  assign in_stall = !in_ready;

  tlsu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .dest_value (dest_value),
    .src_value  (src_value),
    .shift_imm  (shift_imm),
    .carry_in   (carry_in),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .dec        (dec)
  );

  tlsu_shift u_shift (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .shf_valid (shf_valid),
    .shf_ready (shf_ready),
    .shf       (shf)
  );

  tlsu_flags u_flags (
    .clk       (clk),
    .rst       (rst),
    .shf_valid (shf_valid),
    .shf_ready (shf_ready),
    .shf       (shf),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .negative  (negative),
    .zero      (zero),
    .carry_out (carry_out)
  );

endmodule

/* design/tlsu_decode.sv */
// Stage 1: decode the command into a uniform right-shift window and amount.
module tlsu_decode import tlsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [31:0] dest_value,
  input  logic [31:0] src_value,
  input  logic [4:0]  shift_imm,
  input  logic        carry_in,
  output logic        dec_valid,
  input  logic        dec_ready,
  output dec_t        dec
);

  dec_t dec_next;

  assign in_ready = !dec_valid || dec_ready;

  always_comb begin
    logic [7:0] a;
    logic [5:0] imm_amt;
    a = src_value[7:0];
    imm_amt = (shift_imm == 5'd0) ? SHIFT_ALL : {1'b0, shift_imm};
    dec_next.fill  = '0;
    dec_next.value = dest_value;
    dec_next.cin   = carry_in;
    dec_next.amt   = '0;
    dec_next.rev   = 1'b0;
    dec_next.rot_c = 1'b0;
    unique case (cmd)
      CMD_AND: dec_next.value = dest_value & src_value;
      CMD_BIC: dec_next.value = dest_value & ~src_value;
      CMD_EOR: dec_next.value = dest_value ^ src_value;
      CMD_ORR: dec_next.value = dest_value | src_value;
      CMD_MVN: dec_next.value = ~src_value;
      CMD_ASR_IMM: begin
        dec_next.value = src_value;
        dec_next.fill  = {32{src_value[31]}};
        dec_next.amt   = imm_amt;
      end
      CMD_ASR_REG: begin
        dec_next.fill = {32{dest_value[31]}};
        dec_next.amt  = (a >= 8'd32) ? SHIFT_ALL : a[5:0];
      end
      CMD_LSL_IMM: begin
        // left shifts run through the right shifter on the bit-reversed value
        dec_next.value = rev32(src_value);
        dec_next.amt   = {1'b0, shift_imm};
        dec_next.rev   = 1'b1;
      end
      CMD_LSR_IMM: begin
        dec_next.value = src_value;
        dec_next.amt   = imm_amt;
      end
      CMD_LSL_REG: begin
        dec_next.value = rev32(dest_value);
        dec_next.amt   = (a >= 8'd33) ? SHIFT_OUT : a[5:0];
        dec_next.rev   = 1'b1;
      end
      CMD_LSR_REG: begin
        dec_next.amt = (a >= 8'd33) ? SHIFT_OUT : a[5:0];
      end
      CMD_ROR: begin
        dec_next.fill  = dest_value;
        dec_next.amt   = {1'b0, a[4:0]};
        dec_next.rot_c = (a != 8'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (in_ready) begin
      dec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dec <= dec_next;
    end
  end

endmodule

/* design/tlsu_shift.sv */
// Stages 2 and 3: coarse and fine right shift of the decoded window.
module tlsu_shift import tlsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic dec_valid,
  output logic dec_ready,
  input  dec_t dec,
  output logic shf_valid,
  input  logic shf_ready,
  output shf_t shf
);

  logic crs_valid;
  logic crs_ready;
  crs_t crs;
  crs_t crs_next;
  shf_t shf_next;

  assign dec_ready = !crs_valid || crs_ready;
  assign crs_ready = !shf_valid || shf_ready;

  always_comb begin
    logic [64:0] w;
    w = {dec.fill, dec.value, dec.cin};
    case (dec.amt[5:3])
      3'd0:    crs_next.win = w[39:0];
      3'd1:    crs_next.win = w[47:8];
      3'd2:    crs_next.win = w[55:16];
      3'd3:    crs_next.win = w[63:24];
      3'd4:    crs_next.win = {7'd0, w[64:32]};
      default: crs_next.win = '0;
    endcase
    crs_next.fine  = dec.amt[2:0];
    crs_next.rev   = dec.rev;
    crs_next.rot_c = dec.rot_c;
  end

  always_comb begin
    logic [39:0] t;
    logic [31:0] r;
    t = crs.win >> crs.fine;
    // bit 0 of the window holds the last bit shifted out
    r = crs.rev ? rev32(t[32:1]) : t[32:1];
    shf_next.result = r;
    shf_next.carry  = crs.rot_c ? r[31] : t[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crs_valid <= 1'b0;
      shf_valid <= 1'b0;
    end else begin
      if (dec_ready) begin
        crs_valid <= dec_valid;
      end
      if (crs_ready) begin
        shf_valid <= crs_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ready && dec_valid) begin
      crs <= crs_next;
    end
    if (crs_ready && crs_valid) begin
      shf <= shf_next;
    end
  end

endmodule

/* design/tlsu_flags.sv */
// Stage 4: flag generation and output register.
module tlsu_flags import tlsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        shf_valid,
  output logic        shf_ready,
  input  shf_t        shf,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result,
  output logic        negative,
  output logic        zero,
  output logic        carry_out
);

  assign shf_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (shf_ready) begin
      out_valid <= shf_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shf_ready && shf_valid) begin
      result    <= shf.result;
      negative  <= shf.result[31];
      zero      <= (shf.result == 32'd0);
      carry_out <= shf.carry;
    end
  end

endmodule

/* bench/tb.sv */
// Self-checking bench for the Thumb logical and shift unit, with a scoreboard class and drivers.
module tb import tlsu_pkg::*;;

  localparam logic [3:0] CMD_SPARE_FIRST = 4'd12;
  localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;
  localparam int RANDOM_BEATS   = 1400;
  localparam int IDLE_LIMIT     = 2000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_CAP     = 100;

  typedef struct packed {
    logic [31:0] result;
    logic        negative;
    logic        zero;
    logic        carry_out;
  } alu_flags_t;

  class alu_scoreboard;
    alu_flags_t pending_results[$];
    int         failures = 0;
    int         reports  = 0;

    // Execute one instruction: result and the new N, Z and C flags
    function alu_flags_t execute_op(logic [3:0] op, logic [31:0] d, logic [31:0] s,
                                    logic [4:0] imm, logic c_in);
      alu_flags_t  f;
      logic [31:0] r;
      logic        c;
      int          amt;
      int          k;
      int          n;
      r   = d;
      c   = c_in;
      amt = int'(s[7:0]);
      k   = int'(imm);
      case (op)
        CMD_AND: r = d & s;
        CMD_BIC: r = d & ~s;
        CMD_EOR: r = d ^ s;
        CMD_ORR: r = d | s;
        CMD_MVN: r = ~s;
        CMD_ASR_IMM: begin
          if (k == 0) begin
            r = {32{s[31]}};
            c = s[31];
          end else begin
            r = $signed(s) >>> k;
            c = s[k-1];
          end
        end
        CMD_ASR_REG: begin
          if (amt == 0) begin
            r = d;
          end else if (amt < 32) begin
            r = $signed(d) >>> amt;
            c = d[amt-1];
          end else begin
            r = {32{d[31]}};
            c = d[31];
          end
        end
        CMD_LSL_IMM: begin
          if (k == 0) begin
            r = s;
          end else begin
            r = s << k;
            c = s[32-k];
          end
        end
        CMD_LSR_IMM: begin
          if (k == 0) begin
            r = '0;
            c = s[31];
          end else begin
            r = s >> k;
            c = s[k-1];
          end
        end
        CMD_LSL_REG: begin
          if (amt == 0) begin
            r = d;
          end else if (amt < 32) begin
            r = d << amt;
            c = d[32-amt];
          end else begin
            r = '0;
            c = (amt == 32) ? d[0] : 1'b0;
          end
        end
        CMD_LSR_REG: begin
          if (amt == 0) begin
            r = d;
          end else if (amt < 32) begin
            r = d >> amt;
            c = d[amt-1];
          end else begin
            r = '0;
            c = (amt == 32) ? d[31] : 1'b0;
          end
        end
        CMD_ROR: begin
          if (amt != 0) begin
            n = amt % 32;
            r = (n == 0) ? d : ((d >> n) | (d << (32 - n)));
            c = r[31];
          end
        end
        default: r = d;
      endcase
      f.result    = r;
      f.negative  = r[31];
      f.zero      = (r == '0);
      f.carry_out = c;
      return f;
    endfunction

    function void note_issue(logic [3:0] op, logic [31:0] d, logic [31:0] s,
                             logic [4:0] imm, logic c_in);
      pending_results.push_back(execute_op(op, d, s, imm, c_in));
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
      failures++;
      if (reports < REPORT_CAP) begin
        reports++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [31:0] r, logic n, logic z, logic c);
      alu_flags_t e;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: result beat %h with nothing outstanding", $time, r);
        return;
      end
      e = pending_results.pop_front();
      if (r !== e.result)    report("result", e.result, r);
      if (n !== e.negative)  report("negative", 32'(e.negative), 32'(n));
      if (z !== e.zero)      report("zero", 32'(e.zero), 32'(z));
      if (c !== e.carry_out) report("carry_out", 32'(e.carry_out), 32'(c));
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  cmd = '0;
  logic [31:0] dest_value = '0;
  logic [31:0] src_value = '0;
  logic [4:0]  shift_imm = '0;
  logic        carry_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result;
  logic        negative;
  logic        zero;
  logic        carry_out;

  alu_scoreboard sb = new();
  int            idle_run = 0;

  thumb_logic_shift_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .dest_value (dest_value),
    .src_value  (src_value),
    .shift_imm  (shift_imm),
    .carry_in   (carry_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result),
    .negative   (negative),
    .zero       (zero),
    .carry_out  (carry_out)
  );

  always #5 clk = ~clk;

  // Check the result beat before noting the input beat of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(result, negative, zero, carry_out);
      if (in_valid && !in_stall) sb.note_issue(cmd, dest_value, src_value, shift_imm, carry_in);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_run <= 0;
      else idle_run <= idle_run + 1;
    end
  end

  initial begin
    wait (idle_run >= IDLE_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one beat and hold it until taken
  task automatic drive_op(logic [3:0] op, logic [31:0] d, logic [31:0] s,
                          logic [4:0] imm, logic c_in);
    cmd        <= op;
    dest_value <= d;
    src_value  <= s;
    shift_imm  <= imm;
    carry_in   <= c_in;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) begin
      dest_value <= $urandom;
      src_value  <= $urandom;
      @(posedge clk);
    end
  endtask

  task automatic drive_random_op();
    logic [3:0]  op;
    logic [31:0] s;
    if ($urandom_range(0, 99) < 6) op = 4'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    else op = 4'($urandom_range(CMD_AND, CMD_ROR));
    s = $urandom;
    // Keep register amounts mostly near the saturation edge
    if ($urandom_range(0, 3) != 0) s[7:0] = 8'($urandom_range(0, 40));
    else if ($urandom_range(0, 3) == 0) s[7:0] = 8'(32 * $urandom_range(0, 7));
    drive_op(op, $urandom, s, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
  endtask

  // Receiver: stall patterns in segments, with one long hold-off
  initial begin
    int seg;
    int len;
    int mode;
    seg = 0;
    wait (!rst);
    forever begin
      if (seg == 4) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else begin
        len  = $urandom_range(1, 60);
        mode = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= i[0];
          endcase
          @(posedge clk);
        end
      end
      seg++;
    end
  end

  initial begin
    int left;
    int burst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    drive_op(CMD_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 5'd31, 1'b1);
    drive_op(CMD_BIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b0);
    drive_op(CMD_EOR, 32'h0000_0000, 32'h8000_0001, 5'd1, 1'b1);
    drive_op(CMD_ORR, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0);
    drive_op(CMD_MVN, 32'h1234_5678, 32'hFFFF_FFFF, 5'd0, 1'b1);
    drive_op(CMD_MVN, 32'h1234_5678, 32'h0000_0000, 5'd0, 1'b0);
    drive_op(CMD_ASR_IMM, 32'h0, 32'h8000_0000, 5'd0, 1'b0);
    drive_op(CMD_ASR_IMM, 32'h0, 32'h7FFF_FFFF, 5'd0, 1'b1);
    drive_op(CMD_ASR_IMM, 32'h0, 32'hC000_0001, 5'd31, 1'b0);
    drive_op(CMD_LSR_IMM, 32'h0, 32'hFFFF_FFFF, 5'd0, 1'b0);
    drive_op(CMD_LSR_IMM, 32'h0, 32'h8000_0000, 5'd31, 1'b0);
    drive_op(CMD_LSL_IMM, 32'h0, 32'hDEAD_BEEF, 5'd0, 1'b1);
    drive_op(CMD_LSL_IMM, 32'h0, 32'h0000_0003, 5'd31, 1'b0);
    drive_op(CMD_LSL_REG, 32'h0000_0001, 32'hFFFF_FF20, 5'd0, 1'b0);
    drive_op(CMD_LSL_REG, 32'hFFFF_FFFF, 32'h0000_0021, 5'd0, 1'b1);
    drive_op(CMD_LSR_REG, 32'h8000_0000, 32'h0000_0020, 5'd0, 1'b0);
    drive_op(CMD_LSR_REG, 32'hFFFF_FFFF, 32'h0000_00FF, 5'd0, 1'b1);
    drive_op(CMD_LSR_REG, 32'hF0F0_F0F0, 32'hFFFF_FF00, 5'd0, 1'b1);
    drive_op(CMD_ASR_REG, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b0);
    drive_op(CMD_ASR_REG, 32'h8000_0000, 32'h0000_0028, 5'd0, 1'b0);
    drive_op(CMD_ASR_REG, 32'h8000_0001, 32'h0000_001F, 5'd0, 1'b1);
    drive_op(CMD_ROR, 32'h8000_0001, 32'h0000_0020, 5'd0, 1'b0);
    drive_op(CMD_ROR, 32'h0000_0001, 32'h0000_0100, 5'd0, 1'b1);
    drive_op(CMD_ROR, 32'h0000_0081, 32'h0000_0007, 5'd0, 1'b0);
    drive_op(CMD_SPARE_FIRST, 32'h8000_0000, 32'hFFFF_FFFF, 5'd3, 1'b1);
    drive_op(CMD_SPARE_LAST, 32'h0000_0000, 32'h1234_5678, 5'd9, 1'b0);

    left = RANDOM_BEATS;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) drive_random_op();
      left -= burst;
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.outstanding() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.outstanding());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tlsu_pkg.sv
design/tlsu_decode.sv
design/tlsu_shift.sv
design/tlsu_flags.sv
design/thumb_logic_shift_unit.sv
bench/tb.sv
